// ===== hw/rtl/utf8v_pkg.sv =====
`default_nettype none
package utf8v_pkg;

    // width of the byte offset counters
    localparam int OFFSET_BITS = 32;
    localparam int RESULT_OFFSET_BITS = 32;

    // lead byte ranges
    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;

    // continuation byte form 10xxxxxx
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // sequence widths
    localparam logic [2:0] SEQ_LEN_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN_2    = 3'd2;
    localparam logic [2:0] SEQ_LEN_3    = 3'd3;
    localparam logic [2:0] SEQ_LEN_4    = 3'd4;

    // code point limits
    localparam logic [20:0] MIN_CP_2   = 21'h00080;
    localparam logic [20:0] MIN_CP_3   = 21'h00800;
    localparam logic [20:0] MIN_CP_4   = 21'h10000;
    localparam logic [20:0] MAX_CP     = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST = 21'h0D800;
    localparam logic [20:0] SURR_LAST  = 21'h0DFFF;

    typedef logic [OFFSET_BITS-1:0] t_pos;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic                          text_valid;
        logic [RESULT_OFFSET_BITS-1:0] error_offset;
    } t_out;

    // overlong, above range or surrogate
    function automatic logic value_out_of_range(logic [20:0] cp, logic [2:0] len);
        logic [20:0] least;
        least = MIN_CP_2;
        if (len == SEQ_LEN_3) least = MIN_CP_3;
        if (len == SEQ_LEN_4) least = MIN_CP_4;
        return (cp < least) || (cp > MAX_CP) || ((cp >= SURR_FIRST) && (cp <= SURR_LAST));
    endfunction

    // low bits of an offset for the result field
    function automatic logic [RESULT_OFFSET_BITS-1:0] result_offset(t_pos pos);
        logic [63:0] wide;
        wide = 64'(pos);
        return wide[RESULT_OFFSET_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/utf8v_in_stage.sv =====
`default_nettype none
module utf8v_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire utf8v_pkg::t_in i_data,
    input  wire logic          i_take,
    output logic               o_valid,
    output utf8v_pkg::t_in     o_data
);

    logic           r_vld;
    logic           n_vld;
    utf8v_pkg::t_in r_item;

    // room when empty or when the held byte leaves this cycle
    assign o_ready = !r_vld || i_take;

    always_comb begin
        n_vld = r_vld;
        if (i_take) n_vld = 1'b0;
        if (i_valid && o_ready) n_vld = 1'b1;
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // payload register, loaded on each input transfer
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_item;

endmodule
`default_nettype wire

// ===== hw/rtl/utf8v_core.sv =====
`default_nettype none
module utf8v_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire utf8v_pkg::t_in i_item,
    output utf8v_pkg::t_out     o_result
);

    utf8v_pkg::t_pos r_pos;
    utf8v_pkg::t_pos n_pos;
    utf8v_pkg::t_pos r_seq_start;
    utf8v_pkg::t_pos n_seq_start;
    logic [2:0]      r_seq_len;
    logic [2:0]      n_seq_len;
    logic [1:0]      r_remaining;
    logic [1:0]      n_remaining;
    logic [20:0]     r_acc;
    logic [20:0]     n_acc;
    logic            r_err;
    logic            n_err;
    logic            r_fault;
    logic            n_fault;
    utf8v_pkg::t_pos r_err_pos;
    utf8v_pkg::t_pos n_err_pos;

    // per-byte state update
    always_comb begin
        logic [7:0] b;
        logic [2:0] w;
        logic [20:0] lead_bits;
        logic       fin_err;
        utf8v_pkg::t_pos fin_pos;
        b           = i_item.data_byte;
        w           = utf8v_pkg::SEQ_LEN_NONE;
        lead_bits   = '0;
        n_pos       = r_pos;
        n_seq_start = r_seq_start;
        n_seq_len   = r_seq_len;
        n_remaining = r_remaining;
        n_acc       = r_acc;
        n_err       = r_err;
        n_fault     = r_fault;
        n_err_pos   = r_err_pos;

        // lead byte decode
        priority if (b <= utf8v_pkg::ASCII_MAX) begin
            w = 3'd1;
        end else if (b >= utf8v_pkg::LEAD2_MIN && b <= utf8v_pkg::LEAD2_MAX) begin
            w = utf8v_pkg::SEQ_LEN_2;
            lead_bits = {16'd0, b[4:0]};
        end else if (b >= utf8v_pkg::LEAD3_MIN && b <= utf8v_pkg::LEAD3_MAX) begin
            w = utf8v_pkg::SEQ_LEN_3;
            lead_bits = {17'd0, b[3:0]};
        end else if (b >= utf8v_pkg::LEAD4_MIN && b <= utf8v_pkg::LEAD4_MAX) begin
            w = utf8v_pkg::SEQ_LEN_4;
            lead_bits = {18'd0, b[2:0]};
        end else begin
            w = utf8v_pkg::SEQ_LEN_NONE;
        end

        if (!r_err) begin
            if (r_remaining == 2'd0) begin
                // start of a character
                if (w == utf8v_pkg::SEQ_LEN_NONE) begin
                    n_err     = 1'b1;
                    n_err_pos = r_pos;
                end else if (w > 3'd1) begin
                    n_seq_start = r_pos;
                    n_seq_len   = w;
                    n_remaining = 2'(w - 3'd1);
                    n_acc       = lead_bits;
                    n_fault     = 1'b0;
                end
            end else begin
                // continuation byte, first bad one remembered
                if (((b & utf8v_pkg::CONT_MASK) != utf8v_pkg::CONT_TAG) && !r_fault) begin
                    n_fault   = 1'b1;
                    n_err_pos = r_pos;
                end
                n_acc       = {r_acc[14:0], b[5:0]};
                n_remaining = r_remaining - 2'd1;
                if (n_remaining == 2'd0) begin
                    if (n_fault) begin
                        n_err = 1'b1;
                    end else if (utf8v_pkg::value_out_of_range(n_acc, r_seq_len)) begin
                        n_err     = 1'b1;
                        n_err_pos = r_seq_start;
                    end
                    n_fault = 1'b0;
                end
            end
        end

        // saturating offset counter
        if (!(&r_pos)) n_pos = r_pos + 1'b1;

        // end of text: truncated sequence reported at its lead
        fin_err = n_err;
        fin_pos = n_err_pos;
        if (!n_err && n_remaining != 2'd0) begin
            fin_err = 1'b1;
            fin_pos = n_seq_start;
        end
        o_result.text_valid   = !fin_err;
        o_result.error_offset = fin_err ? utf8v_pkg::result_offset(fin_pos) : '0;

        if (i_item.last_byte) begin
            n_pos       = '0;
            n_seq_start = '0;
            n_seq_len   = utf8v_pkg::SEQ_LEN_NONE;
            n_remaining = 2'd0;
            n_acc       = '0;
            n_err       = 1'b0;
            n_fault     = 1'b0;
            n_err_pos   = '0;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_seq_start <= '0;
            r_seq_len   <= utf8v_pkg::SEQ_LEN_NONE;
            r_remaining <= 2'd0;
            r_acc       <= '0;
            r_err       <= 1'b0;
            r_fault     <= 1'b0;
            r_err_pos   <= '0;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_seq_start <= n_seq_start;
            r_seq_len   <= n_seq_len;
            r_remaining <= n_remaining;
            r_acc       <= n_acc;
            r_err       <= n_err;
            r_fault     <= n_fault;
            r_err_pos   <= n_err_pos;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/utf8v_out_stage.sv =====
`default_nettype none
module utf8v_out_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire utf8v_pkg::t_out i_data,
    output logic                 o_free,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output utf8v_pkg::t_out      o_data
);

    logic            r_vld;
    logic            n_vld;
    utf8v_pkg::t_out r_data;

    // free when empty or when the held result transfers now
    assign o_free = !r_vld || i_ready;

    always_comb begin
        n_vld = r_vld;
        if (r_vld && i_ready) n_vld = 1'b0;
        if (i_load) n_vld = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ===== hw/rtl/utf8_stream_validator.sv =====
// the final byte is held in the input register; its result loads into the result register when it steps
// throughput: one byte per cycle; the final byte waits only while a result is held
// the input register, the decoder and the result register set that figure
// reset: synchronous, active low; clears all decoder state and both valid flags
// after each final byte the decoder returns to its reset state for the next text
`default_nettype none
module utf8_stream_validator (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire utf8v_pkg::t_in  i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output utf8v_pkg::t_out      o_out_data
);

    logic            stage_valid;
    utf8v_pkg::t_in  stage_item;
    logic            step;
    logic            out_free;
    utf8v_pkg::t_out result;

    // input register
    utf8v_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .i_take  (step),
        .o_valid (stage_valid),
        .o_data  (stage_item)
    );

    // a byte steps when its result, if any, has room
    assign step = stage_valid && (!stage_item.last_byte || out_free);

    utf8v_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (stage_item),
        .o_result (result)
    );

    // result register
    utf8v_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && stage_item.last_byte),
        .i_data  (result),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/utf8v_checker.sv =====
`default_nettype none
module utf8v_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            o_in_ready,
    input wire utf8v_pkg::t_in  i_in_data,
    input wire logic            o_out_valid,
    input wire logic            i_out_ready,
    input wire utf8v_pkg::t_out o_out_data
);

    // held result stays until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed before transfer");

    // a valid text carries a zero offset
    a_valid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.text_valid |-> o_out_data.error_offset == '0)
        else $error("valid text with nonzero offset");

    // with no result held the input side never stalls
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule

bind utf8_stream_validator utf8v_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire
